>>> hw/rtl/wsts_pkg.sv
// ----------------------------------------------------------------------------
// wsts_pkg
// Shared types, codes and defaults for the work-stealing task scheduler.
// ----------------------------------------------------------------------------
package wsts_pkg;

  localparam int NUM_PROCS_DEF   = 4;
  localparam int DEQUE_DEPTH_DEF = 32;
  localparam int ID_W            = 16;
  localparam int RND_W           = 16;
  localparam int BATCH_W         = 6;

  // event codes on the command field
  localparam logic [1:0] CMD_ARRIVE = 2'd0;
  localparam logic [1:0] CMD_FINISH = 2'd1;
  localparam logic [1:0] CMD_STEAL  = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_IGNORED   = 2'd1;
  localparam logic [1:0] ST_DROPPED   = 2'd2;
  localparam logic [1:0] ST_NO_VICTIM = 2'd3;

  // register index of batch_size
  localparam logic REG_BATCH = 1'b0;

  typedef struct packed {
    logic [1:0]       command;
    logic [1:0]       worker;
    logic [RND_W-1:0] random_value;
  } req_t;

  typedef struct packed {
    logic [1:0]      status;
    logic [ID_W-1:0] arrival_id;
    logic            started;
    logic [ID_W-1:0] started_id;
    logic            stolen;
    logic [1:0]      victim;
    logic [4:0]      moved_count;
  } rsp_t;

  // outcome of evaluating one request
  typedef enum logic [1:0] {
    EV_DONE,
    EV_POP,
    EV_STEAL
  } ev_kind_t;

  typedef struct packed {
    logic load_in;
    logic eval;
    logic pop_capture;
    logic div_step;
    logic scan_step;
    logic batch_init;
    logic move_rd;
    logic move_wr;
    logic last_rd;
    logic last_capture;
    logic publish;
  } ctl_cmd_t;

  typedef struct packed {
    ev_kind_t kind;
    logic     div_done;
    logic     scan_done;
    logic     batch_multi;
    logic     last_move;
    logic     out_free;
  } ctl_sts_t;

endpackage

>>> hw/rtl/wsts_if.sv
// ----------------------------------------------------------------------------
// wsts_if
// Valid/ready channels for scheduler requests and results.
// ----------------------------------------------------------------------------
interface wsts_req_if;
  import wsts_pkg::*;
  logic valid;
  logic ready;
  req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface wsts_rsp_if;
  import wsts_pkg::*;
  logic valid;
  logic ready;
  rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> hw/rtl/work_stealing_task_scheduler.sv
// Sequence: an arrival or ignored request is evaluated and published; a finish served from
// its own deque adds a store read, and a steal adds the bit-serial victim divider, the
// candidate scan, a store read and write per moved task and a last read of the victim.
// Throughput: one request at a time; a finished result waits in the output register
// while the next request is taken.
// Reset: synchronous, all workers idle, deques empty, ids from zero, batch_size 1.
// ----------------------------------------------------------------------------
// work_stealing_task_scheduler
// Top level: request/result channels, APB register and sequencer/datapath.
// ----------------------------------------------------------------------------
module work_stealing_task_scheduler #(
  parameter int NUM_PROCS   = wsts_pkg::NUM_PROCS_DEF,
  parameter int DEQUE_DEPTH = wsts_pkg::DEQUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  wsts_req_if.sink    req,
  wsts_rsp_if.source  rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import wsts_pkg::*;

  logic [BATCH_W-1:0] batch;
  ctl_cmd_t           cmd;
  ctl_sts_t           sts;
  logic               reg_hit;

  // batch_size register
  assign reg_hit = (paddr[2] == REG_BATCH);
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? 32'(batch) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      batch <= BATCH_W'(1);
    end else if (psel && penable && pwrite && reg_hit) begin
      batch <= pwdata[BATCH_W-1:0];
    end
  end

  wsts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  wsts_dpath #(
    .NUM_PROCS   (NUM_PROCS),
    .DEQUE_DEPTH (DEQUE_DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .req       (req.payload),
    .batch     (batch),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .out       (rsp.payload)
  );

endmodule

>>> hw/rtl/wsts_ctrl.sv
// ----------------------------------------------------------------------------
// wsts_ctrl
// Sequencer: walks one request through evaluate, divide, scan and batch move.
// ----------------------------------------------------------------------------
module wsts_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  wsts_pkg::ctl_sts_t sts,
  output wsts_pkg::ctl_cmd_t cmd
);
  import wsts_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_EVAL, S_POP, S_DIV, S_SCAN, S_BATCH,
    S_MRD, S_MWR, S_LRD, S_LWT, S_FIN
  } state_t;

  state_t state;
  state_t state_next;

  // advance the sequence
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (in_valid) state_next = S_EVAL;
      S_EVAL: begin
        case (sts.kind)
          EV_POP:   state_next = S_POP;
          EV_STEAL: state_next = S_DIV;
          default:  state_next = S_FIN;
        endcase
      end
      S_POP:   state_next = S_FIN;
      S_DIV:   if (sts.div_done) state_next = S_SCAN;
      S_SCAN:  if (sts.scan_done) state_next = S_BATCH;
      S_BATCH: state_next = sts.batch_multi ? S_MRD : S_LRD;
      S_MRD:   state_next = S_MWR;
      S_MWR:   state_next = sts.last_move ? S_LRD : S_MRD;
      S_LRD:   state_next = S_LWT;
      S_LWT:   state_next = S_FIN;
      S_FIN:   if (sts.out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // decode datapath commands from state
  always_comb begin
    in_ready         = (state == S_IDLE);
    cmd              = '0;
    cmd.load_in      = (state == S_IDLE) && in_valid;
    cmd.eval         = (state == S_EVAL);
    cmd.pop_capture  = (state == S_POP);
    cmd.div_step     = (state == S_DIV);
    cmd.scan_step    = (state == S_SCAN);
    cmd.batch_init   = (state == S_BATCH);
    cmd.move_rd      = (state == S_MRD);
    cmd.move_wr      = (state == S_MWR);
    cmd.last_rd      = (state == S_LRD);
    cmd.last_capture = (state == S_LWT);
    cmd.publish      = (state == S_FIN) && sts.out_free;
  end

endmodule

>>> hw/rtl/wsts_dpath.sv
// ----------------------------------------------------------------------------
// wsts_dpath
// Deque store, per-worker pointers, victim divider and scan, result register.
// ----------------------------------------------------------------------------
module wsts_dpath #(
  parameter int NUM_PROCS   = wsts_pkg::NUM_PROCS_DEF,
  parameter int DEQUE_DEPTH = wsts_pkg::DEQUE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  wsts_pkg::ctl_cmd_t            cmd,
  output wsts_pkg::ctl_sts_t            sts,
  input  wsts_pkg::req_t                req,
  input  logic [wsts_pkg::BATCH_W-1:0]  batch,
  output logic                          out_valid,
  input  logic                          out_ready,
  output wsts_pkg::rsp_t                out
);
  import wsts_pkg::*;

  localparam int PW    = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
  localparam int DW    = $clog2(DEQUE_DEPTH);
  localparam int CW    = $clog2(DEQUE_DEPTH + 1);
  localparam int NW    = $clog2(NUM_PROCS + 1);
  localparam int AW    = $clog2(NUM_PROCS * DEQUE_DEPTH);
  localparam int DEPTH = NUM_PROCS * DEQUE_DEPTH;

  // store and per-worker state
  logic [ID_W-1:0] mem [DEPTH];
  logic [ID_W-1:0] rd_q;
  logic [DW-1:0]   head  [NUM_PROCS];
  logic [CW-1:0]   count [NUM_PROCS];
  logic            busy  [NUM_PROCS];
  logic [ID_W-1:0] next_id;

  // request and working registers
  logic [1:0]       cmd_r;
  logic [1:0]       worker_r;
  logic [RND_W-1:0] rnd_r;
  logic [RND_W-1:0] rem;
  logic [3:0]       div_bit;
  logic [NW-1:0]    n_r;
  logic [PW-1:0]    sj;
  logic [NW-1:0]    sk;
  logic [PW-1:0]    vic;
  logic [BATCH_W-1:0] moves;
  rsp_t             res;

  // combinational helpers
  logic [PW-1:0]   wk;
  logic            in_range;
  logic            ignore;
  logic            is_arrive;
  logic            full_w;
  logic [NW-1:0]   ncand;
  ev_kind_t        kind;
  logic [DW-1:0]   front_dec;
  logic [DW-1:0]   front_inc;
  logic [CW:0]     back_sum;
  logic [DW-1:0]   back_slot;
  logic [BATCH_W-1:0] bs;
  logic            thief_room;
  logic            we;
  logic            re;
  logic [AW-1:0]   waddr;
  logic [AW-1:0]   raddr;
  logic [ID_W-1:0] wdata;
  logic [20:0]     div_shift;
  rsp_t            res_eval;

  assign wk        = PW'(worker_r);
  assign in_range  = 32'(worker_r) < NUM_PROCS;
  assign is_arrive = (cmd_r == CMD_ARRIVE);
  assign full_w    = (count[wk] == CW'(DEQUE_DEPTH));
  assign ignore    = !in_range || (cmd_r != CMD_ARRIVE && cmd_r != CMD_FINISH &&
                     cmd_r != CMD_STEAL) || (cmd_r == CMD_FINISH && !busy[wk]) ||
                     (cmd_r == CMD_STEAL && busy[wk]);

  // count candidate victims
  always_comb begin
    ncand = '0;
    for (int j = 0; j < NUM_PROCS; j++) begin
      ncand = ncand + NW'(count[j] != '0);
    end
  end

  always_comb begin
    if (ignore || is_arrive) begin
      kind = EV_DONE;
    end else if (cmd_r == CMD_FINISH && count[wk] != '0) begin
      kind = EV_POP;
    end else if (ncand == '0) begin
      kind = EV_DONE;
    end else begin
      kind = EV_STEAL;
    end
  end

  // first view of the result, settled at evaluation
  always_comb begin
    res_eval        = '0;
    res_eval.status = ST_IGNORED;
    if (!ignore) begin
      if (is_arrive) begin
        res_eval.arrival_id = next_id;
        if (!busy[wk]) begin
          res_eval.status     = ST_OK;
          res_eval.started    = 1'b1;
          res_eval.started_id = next_id;
        end else if (full_w) begin
          res_eval.status = ST_DROPPED;
        end else begin
          res_eval.status = ST_OK;
        end
      end else if (kind == EV_DONE) begin
        res_eval.status = ST_NO_VICTIM;
      end
    end
  end

  // ring slot arithmetic
  assign front_dec = (head[wk] == '0) ? DW'(DEQUE_DEPTH - 1) : head[wk] - 1'b1;
  assign front_inc = (head[wk] == DW'(DEQUE_DEPTH - 1)) ? '0 : head[wk] + 1'b1;
  assign back_sum  = (CW+1)'(head[vic]) + (CW+1)'(count[vic]) - 1'b1;
  assign back_slot = (back_sum >= (CW+1)'(DEQUE_DEPTH)) ?
                     DW'(back_sum - (CW+1)'(DEQUE_DEPTH)) : DW'(back_sum);
  assign bs         = (batch == '0) ? BATCH_W'(1) : batch;
  assign thief_room = (count[wk] != CW'(DEQUE_DEPTH));
  assign div_shift  = 21'(n_r) << div_bit;

  // store port control
  assign we    = (cmd.eval && is_arrive && !ignore && busy[wk] && !full_w) ||
                 (cmd.move_wr && thief_room);
  assign wdata = cmd.move_wr ? rd_q : next_id;
  assign waddr = AW'(wk) * AW'(DEQUE_DEPTH) + AW'(front_dec);
  assign re    = (cmd.eval && kind == EV_POP) || cmd.move_rd || cmd.last_rd;
  assign raddr = cmd.eval ? AW'(wk) * AW'(DEQUE_DEPTH) + AW'(head[wk])
                          : AW'(vic) * AW'(DEQUE_DEPTH) + AW'(back_slot);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_q <= mem[raddr];
    end
  end

  // status to the sequencer
  always_comb begin
    sts.kind        = kind;
    sts.div_done    = (div_bit == '0);
    sts.scan_done   = (sj == PW'(NUM_PROCS - 1));
    sts.batch_multi = (10'(count[vic]) >= 10'(bs)) && (bs != BATCH_W'(1));
    sts.last_move   = (moves == BATCH_W'(1));
    sts.out_free    = !out_valid || out_ready;
  end

  // worker state, ids and result handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < NUM_PROCS; j++) begin
        head[j]  <= '0;
        count[j] <= '0;
        busy[j]  <= 1'b0;
      end
      next_id   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.eval && !ignore) begin
        if (is_arrive) begin
          next_id <= next_id + 1'b1;
          if (!busy[wk]) begin
            busy[wk] <= 1'b1;
          end else if (!full_w) begin
            head[wk]  <= front_dec;
            count[wk] <= count[wk] + 1'b1;
          end
        end else begin
          busy[wk] <= 1'b0;
          if (kind == EV_POP) begin
            head[wk]  <= front_inc;
            count[wk] <= count[wk] - 1'b1;
          end
        end
      end
      if (cmd.pop_capture || cmd.last_capture) begin
        busy[wk] <= 1'b1;
      end
      if (cmd.move_rd || cmd.last_rd) begin
        count[vic] <= count[vic] - 1'b1;
      end
      if (cmd.move_wr && thief_room) begin
        head[wk]  <= front_dec;
        count[wk] <= count[wk] + 1'b1;
      end
      if (cmd.publish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // request, divider, scan and result payload
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      cmd_r    <= req.command;
      worker_r <= req.worker;
      rnd_r    <= req.random_value;
    end
    if (cmd.eval) begin
      res     <= res_eval;
      rem     <= rnd_r;
      div_bit <= 4'd15;
      n_r     <= ncand;
      sj      <= '0;
      sk      <= '0;
      vic     <= '0;
    end
    // one quotient bit per cycle
    if (cmd.div_step) begin
      if (21'(rem) >= div_shift) begin
        rem <= rem - div_shift[RND_W-1:0];
      end
      div_bit <= div_bit - 1'b1;
    end
    // pick the rem-th non-empty deque
    if (cmd.scan_step) begin
      if (count[sj] != '0) begin
        if (RND_W'(sk) == rem) begin
          vic <= sj;
        end
        sk <= sk + 1'b1;
      end
      sj <= sj + 1'b1;
    end
    if (cmd.batch_init) begin
      moves           <= sts.batch_multi ? bs - 1'b1 : '0;
      res.moved_count <= sts.batch_multi ? 5'(bs - 1'b1) : '0;
    end
    if (cmd.move_wr) begin
      moves <= moves - 1'b1;
    end
    if (cmd.pop_capture) begin
      res.status     <= ST_OK;
      res.started    <= 1'b1;
      res.started_id <= rd_q;
    end
    if (cmd.last_capture) begin
      res.status     <= ST_OK;
      res.started    <= 1'b1;
      res.started_id <= rd_q;
      res.stolen     <= 1'b1;
      res.victim     <= 2'(vic);
    end
    if (cmd.publish) begin
      out <= res;
    end
  end

endmodule

>>> dv/work_stealing_task_scheduler_tb.sv
// ----------------------------------------------------------------------------
// work_stealing_task_scheduler_tb
// Self-checking bench for the work-stealing task scheduler: directed events
// and random phases of arrivals, finishes and steals under several batch
// sizes. Each result is checked field by field against a behavioural model.
// ----------------------------------------------------------------------------
module work_stealing_task_scheduler_tb;
  import wsts_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WORKERS = NUM_PROCS_DEF;
  localparam int DEPTH   = DEQUE_DEPTH_DEF;

  // Scheduler model and store of expected results
  class sched_scoreboard;
    int unsigned        head [WORKERS];
    int unsigned        fill [WORKERS];
    logic [ID_W-1:0]    ring [WORKERS][DEPTH];
    bit                 active [WORKERS];
    logic [ID_W-1:0]    next_task;
    int unsigned        batch;
    rsp_t               awaited [$];
    int                 errors;

    function new();
      foreach (head[i]) begin
        head[i] = 0;
        fill[i] = 0;
        active[i] = 0;
      end
      next_task = '0;
      batch = 1;
      errors = 0;
    endfunction

    function void add_front(int unsigned w, logic [ID_W-1:0] id);
      head[w] = (head[w] + DEPTH - 1) % DEPTH;
      ring[w][head[w]] = id;
      fill[w]++;
    endfunction

    function logic [ID_W-1:0] take_front(int unsigned w);
      logic [ID_W-1:0] id;
      id = ring[w][head[w]];
      head[w] = (head[w] + 1) % DEPTH;
      fill[w]--;
      return id;
    endfunction

    function logic [ID_W-1:0] take_back(int unsigned w);
      int unsigned s;
      s = (head[w] + fill[w] - 1) % DEPTH;
      fill[w]--;
      return ring[w][s];
    endfunction

    // Predict the result of one accepted request and queue it
    function void note_request(req_t r);
      rsp_t e;
      int unsigned w, cand [WORKERS], n, v, bs;
      e = '0;
      e.status = ST_IGNORED;
      w = 32'(r.worker);
      n = 0;
      if (w < WORKERS) begin
        if (r.command == CMD_ARRIVE) begin
          e.arrival_id = next_task;
          if (!active[w]) begin
            active[w] = 1'b1;
            e.started = 1'b1;
            e.started_id = next_task;
            e.status = ST_OK;
          end else if (fill[w] >= DEPTH) begin
            e.status = ST_DROPPED;
          end else begin
            add_front(w, next_task);
            e.status = ST_OK;
          end
          next_task++;
        end else if ((r.command == CMD_FINISH && active[w]) ||
                     (r.command == CMD_STEAL && !active[w])) begin
          active[w] = 1'b0;
          if (r.command == CMD_FINISH && fill[w] > 0) begin
            active[w] = 1'b1;
            e.started = 1'b1;
            e.started_id = take_front(w);
            e.status = ST_OK;
          end else begin
            for (int j = 0; j < WORKERS; j++)
              if (fill[j] > 0) cand[n++] = j;
            if (n == 0) begin
              e.status = ST_NO_VICTIM;
            end else begin
              v = cand[r.random_value % n];
              bs = (batch == 0) ? 1 : batch;
              if (fill[v] >= bs) begin
                for (int k = 1; k < bs; k++) begin
                  logic [ID_W-1:0] t;
                  t = take_back(v);
                  if (fill[w] < DEPTH) add_front(w, t);
                  e.moved_count++;
                end
              end
              active[w] = 1'b1;
              e.started = 1'b1;
              e.started_id = take_back(v);
              e.stolen = 1'b1;
              e.victim = 2'(v);
              e.status = ST_OK;
            end
          end
        end
      end
      awaited.insert(awaited.size(), e);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
      errors++;
    endtask

    // Compare one accepted result with the oldest expectation
    task check_result(rsp_t g);
      rsp_t e;
      if (awaited.size() == 0) begin
        report("unexpected result", 32'(g.arrival_id), 32'd0);
        return;
      end
      e = awaited[0];
      awaited.delete(0);
      if (g.status !== e.status) report("status", 32'(g.status), 32'(e.status));
      if (g.arrival_id !== e.arrival_id)
        report("arrival_id", 32'(g.arrival_id), 32'(e.arrival_id));
      if (g.started !== e.started) report("started", 32'(g.started), 32'(e.started));
      if (g.started_id !== e.started_id)
        report("started_id", 32'(g.started_id), 32'(e.started_id));
      if (g.stolen !== e.stolen) report("stolen", 32'(g.stolen), 32'(e.stolen));
      if (g.victim !== e.victim) report("victim", 32'(g.victim), 32'(e.victim));
      if (g.moved_count !== e.moved_count)
        report("moved_count", 32'(g.moved_count), 32'(e.moved_count));
    endtask
  endclass

  logic clk = 0, rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  bit          calm = 0;      // no idling in the closing part
  bit          hold_off = 0;  // ask the receiver for a long stall

  wsts_req_if req ();
  wsts_rsp_if rsp ();

  sched_scoreboard sb = new();

  work_stealing_task_scheduler dut (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    req.valid = 0;
    req.payload = '0;
    rsp.ready = 0;
  end

  // Collect results
  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) sb.check_result(rsp.payload);
  end

  // Result receiver: random stalls, plus one long hold on request
  initial begin
    int n;
    @(negedge rst);
    forever begin
      if (hold_off) begin
        rsp.ready <= 0;
        for (n = 0; n < 400; n++) @(posedge clk);
        hold_off = 0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        rsp.ready <= 0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else begin
        rsp.ready <= 1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  // Write batch_size and read it back over the register port
  task write_batch(logic [31:0] val);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1;
    paddr <= 3'(4 * REG_BATCH); pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    sb.batch = val & 32'h3F;
    pwrite <= 0; penable <= 0;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    if (prdata[BATCH_W-1:0] !== val[BATCH_W-1:0])
      sb.report("batch_size readback", prdata, val & 32'h3F);
    psel <= 0; penable <= 0;
  endtask

  // Offer one request; valid stays high unless a gap follows
  task send(logic [1:0] cmd, logic [1:0] w, logic [RND_W-1:0] rnd);
    req_t r;
    r.command = cmd;
    r.worker = w;
    r.random_value = rnd;
    req.valid <= 1;
    req.payload <= r;
    do @(posedge clk); while (!req.ready);
    sb.note_request(r);
    if (!calm && $urandom_range(0, 4) == 0) begin
      req.valid <= 0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  task drain();
    req.valid <= 0;
    wait (sb.awaited.size() == 0);
    repeat (120) @(posedge clk);
  endtask

  // Random event of a phase; flood phases pile arrivals on one worker
  task random_event(bit flood, logic [1:0] fav);
    int p;
    logic [1:0] cmd, w;
    p = $urandom_range(0, 99);
    w = 2'($urandom_range(0, 3));
    if (flood) begin
      cmd = (p < 85) ? CMD_ARRIVE : (p < 93) ? CMD_STEAL : CMD_FINISH;
      if (cmd == CMD_ARRIVE) w = fav;
    end else begin
      cmd = (p < 40) ? CMD_ARRIVE : (p < 72) ? CMD_FINISH : (p < 95) ? CMD_STEAL : 2'd3;
    end
    send(cmd, w, 16'($urandom_range(0, 65535)));
  endtask

  initial begin
    logic [31:0] batches [10];
    batches = '{32'd1, 32'd32, 32'd0, 32'd63, 32'd4, 32'd2, 32'd32, 32'd1, 32'd8, 32'd17};
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: ignored events, empty steals, starts, queueing, batch steal
    send(CMD_FINISH, 2'd1, 16'h0000);
    send(CMD_STEAL,  2'd2, 16'hFFFF);
    send(2'd3,       2'd3, 16'h1234);
    send(CMD_ARRIVE, 2'd0, 16'h0000);
    send(CMD_STEAL,  2'd0, 16'h0000);
    for (int i = 0; i < 6; i++) send(CMD_ARRIVE, 2'd0, 16'h0000);
    send(CMD_ARRIVE, 2'd3, 16'hFFFF);
    send(CMD_ARRIVE, 2'd3, 16'h0000);
    send(CMD_STEAL,  2'd1, 16'hFFFF);
    send(CMD_FINISH, 2'd1, 16'h0001);
    drain();
    write_batch(32'd3);
    send(CMD_STEAL,  2'd2, 16'h0000);
    send(CMD_FINISH, 2'd2, 16'h8000);
    send(CMD_FINISH, 2'd0, 16'h5555);
    send(CMD_FINISH, 2'd3, 16'hAAAA);
    send(CMD_FINISH, 2'd3, 16'h0000);
    drain();

    // Random phases under several batch sizes
    for (int ph = 0; ph < 10; ph++) begin
      write_batch(batches[ph]);
      if (ph == 8) calm = 1;
      for (int i = 0; i < 160; i++) begin
        if (ph == 2 && i == 20) hold_off = 1;
        if (ph == 4 && i == 80) begin
          req.valid <= 0;
          wait (sb.awaited.size() == 0);
          @(posedge clk);
        end
        random_event(i < 60 && ph % 2 == 1, 2'(ph));
      end
      drain();
    end

    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
